>>> rtl/core/mavg_pkg.sv
// Shared constants, state encoding and controller/datapath interface types.
package mavg_pkg;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W       = SAMPLE_BITS + ADDR_W + 1;
	localparam int FRAC_BITS   = 8;
	localparam int DIV_W       = SUM_W + FRAC_BITS;
	localparam int STEP_W      = $clog2(DIV_W + 1);
	localparam int MEAN_W      = 24;
	localparam int CFG_W       = 7;
	localparam int OUT_W       = ((MEAN_W + CNT_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(4);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV_INIT,
		ST_DIV,
		ST_FINISH
	} mavg_state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic div_init;
		logic div_step;
		logic out_load;
	} mavg_cmd_t;

	typedef struct packed {
		logic div_done;
	} mavg_sts_t;

endpackage

>>> rtl/core/mavg_div.sv
// Restoring unsigned divider, one quotient bit per step.
module mavg_div
	import mavg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             init,
	input  logic             step,
	input  logic [DIV_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output logic             done
);

	logic [DIV_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CNT_W:0]    rem_sh;
	logic              fits;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (init) begin
			cnt_q <= STEP_W'(DIV_W);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step && cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? CNT_W'(rem_sh - {1'b0, dvs_q}) : CNT_W'(rem_sh);
		end
	end

	assign quotient = quo_q;
	assign done     = (cnt_q == '0);

endmodule

>>> rtl/core/mavg_dp.sv
// Datapath: sample ring, running sum, fill count, divider and result register.
module mavg_dp
	import mavg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  mavg_cmd_t              cmd,
	output mavg_sts_t              sts,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic                   in_clear,
	output logic [OUT_W-1:0]       out_data
);

	localparam logic [DIV_W-1:0] POS_LIM = DIV_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
	localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(64'd1 << (MEAN_W - 1));

	logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

	logic [CFG_W-1:0]              window_q;
	logic [ADDR_W-1:0]             wslot_q;
	logic [CNT_W-1:0]              fill_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] oldest_q;
	logic                          neg_q;
	logic [MEAN_W-1:0]             mean_q;
	logic [CNT_W-1:0]              count_q;

	logic [CNT_W-1:0]  fill_eff;
	logic [ADDR_W-1:0] fmod;
	logic [ADDR_W-1:0] oldest_addr;
	logic [CNT_W-1:0]  win_eff;
	logic              drop;
	logic [SUM_W-1:0]  sum_mag;
	logic [DIV_W-1:0]  dividend;
	logic [DIV_W-1:0]  quot;
	logic [MEAN_W-1:0] mag24;
	logic [MEAN_W-1:0] mean_d;

	always_comb begin
		fill_eff = in_clear ? '0 : fill_q;
		fmod     = (fill_eff == CNT_W'(MAX_WINDOW)) ? '0 : ADDR_W'(fill_eff);
		if (wslot_q >= fmod) begin
			oldest_addr = wslot_q - fmod;
		end else begin
			oldest_addr = ADDR_W'(wslot_q + ADDR_W'(MAX_WINDOW) - fmod);
		end
		if (window_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = CNT_W'(window_q);
		end
		drop     = (fill_q >= win_eff);
		sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		dividend = {sum_mag, {FRAC_BITS{1'b0}}};
		mag24    = MEAN_W'(quot);
		if (!neg_q) begin
			mean_d = (quot > POS_LIM) ? MEAN_W'(POS_LIM) : mag24;
		end else begin
			mean_d = (quot > NEG_LIM) ? MEAN_W'(NEG_LIM) : MEAN_W'(-mag24);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			wslot_q  <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (cmd.load) begin
				fill_q <= fill_eff;
				if (in_clear) begin
					sum_q <= '0;
				end
			end else if (cmd.update) begin
				if (!drop) begin
					fill_q <= fill_q + CNT_W'(1);
				end
				sum_q <= sum_q + SUM_W'(sample_q) - (drop ? SUM_W'(oldest_q) : '0);
				wslot_q <= (int'(wslot_q) == MAX_WINDOW - 1) ? '0 : wslot_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_sample;
			oldest_q <= ring[oldest_addr];
		end
		if (cmd.update) begin
			ring[wslot_q] <= sample_q;
		end
		if (cmd.div_init) begin
			neg_q <= sum_q[SUM_W-1];
		end
		if (cmd.out_load) begin
			mean_q  <= mean_d;
			count_q <= fill_q;
		end
	end

	mavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (cmd.div_init),
		.step     (cmd.div_step),
		.dividend (dividend),
		.divisor  (fill_q),
		.quotient (quot),
		.done     (sts.div_done)
	);

	assign out_data = OUT_W'({count_q, mean_q});

endmodule

>>> rtl/core/mavg_ctrl.sv
// Controller: sequences sample update, division and result hand-off.
module mavg_ctrl
	import mavg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output mavg_cmd_t cmd,
	input  mavg_sts_t sts
);

	mavg_state_t state_q;
	mavg_state_t state_d;
	logic        m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

	a_accept_updates: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_UPDATE))
		else $error("accepted request not followed by update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten while held");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_INIT) |=> !sts.div_done)
		else $error("divider reports done right after init");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("pending result dropped");

endmodule

>>> rtl/core/moving_average_filter.sv
// Top level of the simple moving average filter.
// Each accepted request carries one signed sample (and a clear flag that empties the
// window first) and yields one result: the mean of the last window_size samples in
// signed Q15.8, truncated toward zero, plus the number of samples averaged. An item
// occupies the block from the cycle in which it is accepted, which reads the oldest
// sample from the ring. Then ST_UPDATE updates the running sum, ST_DIV_INIT loads the
// divider, ST_DIV runs the bit-serial divider (31 quotient bits plus a done check) and
// ST_FINISH loads the result register, after which the block is idle again; no new
// request is accepted before then. A result waiting in the output register does not
// block acceptance of the next sample; only a second finished result waits for it.
// Write window_size only while the block is idle.
module moving_average_filter
	import mavg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
	input  logic                   s_tuser,   // [0] clear_before
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_W-1:0]       m_tdata,   // [23:0] mean, [30:24] count, [31] zero
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata  // window_size
);

	mavg_cmd_t cmd;
	mavg_sts_t sts;

	mavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mavg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_sample (s_tdata),
		.in_clear  (s_tuser),
		.out_data  (m_tdata)
	);

endmodule

>>> tb/mavg_checker.sv
`timescale 1ns / 100ps
// Moving average checker: tracks window state, predicts each mean and compares results.
module mavg_checker
	import mavg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [SAMPLE_BITS-1:0] s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_W-1:0]       m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,
	output int                     result_count,
	output int                     fail_count
);

	localparam int PEND_DEPTH = 64;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [CNT_W-1:0]  count;
	} window_avg_t;

	window_avg_t       expected_means[PEND_DEPTH];
	int                pend_wr;
	int                pend_rd;
	logic [CFG_W-1:0]  window_reg;
	int                ring[MAX_WINDOW];
	int                slot;
	int                fill;
	longint            sum;
	int                mismatches;

	assign fail_count = mismatches;

	function automatic window_avg_t slide_window(logic signed [SAMPLE_BITS-1:0] smp, logic clr);
		int          span;
		int          oldest;
		longint      q;
		window_avg_t r;
		if (window_reg == 0)
			span = 1;
		else if (window_reg > MAX_WINDOW)
			span = MAX_WINDOW;
		else
			span = int'(window_reg);
		if (clr) begin
			fill = 0;
			sum  = 0;
		end
		// full (or wider than a shrunk window): drop exactly one oldest sample
		if (fill >= span) begin
			oldest = (slot + MAX_WINDOW - (fill % MAX_WINDOW)) % MAX_WINDOW;
			sum    = sum - ring[oldest];
		end else begin
			fill = fill + 1;
		end
		ring[slot] = int'(smp);
		sum        = sum + longint'(smp);
		slot       = (slot + 1) % MAX_WINDOW;
		q = (sum * 256) / fill;
		if (q < -(longint'(1) << (MEAN_W - 1)))
			q = -(longint'(1) << (MEAN_W - 1));
		if (q > (longint'(1) << (MEAN_W - 1)) - 1)
			q = (longint'(1) << (MEAN_W - 1)) - 1;
		r.mean  = q[MEAN_W-1:0];
		r.count = fill[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		window_avg_t want;
		logic [MEAN_W-1:0] got_mean;
		logic [CNT_W-1:0]  got_count;
		if (!arst_n) begin
			window_reg = WINDOW_RESET;
			slot       = 0;
			fill       = 0;
			sum        = 0;
			mismatches = 0;
			pend_wr    = 0;
			pend_rd    = 0;
			result_count <= 0;
		end else begin
			if (cfg_we)
				window_reg = cfg_wdata;
			if (s_tvalid && s_tready) begin
				expected_means[pend_wr % PEND_DEPTH] = slide_window($signed(s_tdata), s_tuser);
				pend_wr = pend_wr + 1;
			end
			if (m_tvalid && m_tready) begin
				result_count <= result_count + 1;
				got_mean  = m_tdata[MEAN_W-1:0];
				got_count = m_tdata[MEAN_W +: CNT_W];
				if (pend_wr == pend_rd) begin
					if (mismatches < 10)
						$display("%0t: unexpected result mean %0d count %0d", $realtime,
							$signed(got_mean), got_count);
					mismatches = mismatches + 1;
				end else begin
					want    = expected_means[pend_rd % PEND_DEPTH];
					pend_rd = pend_rd + 1;
					if (got_mean !== want.mean || got_count !== want.count) begin
						if (mismatches < 10)
							$display("%0t: mismatch: expected mean %0d count %0d, got mean %0d count %0d",
								$realtime, $signed(want.mean), want.count,
								$signed(got_mean), got_count);
						mismatches = mismatches + 1;
					end
				end
			end
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, sample stimulus, result backpressure and final verdict.
module tb;
	import mavg_pkg::*;

	localparam int LIMIT = 400000;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic [SAMPLE_BITS-1:0] s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tready  = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_W-1:0]       cfg_wdata = WINDOW_RESET;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_W-1:0]       m_tdata;

	logic calm      = 1'b0;
	logic held      = 1'b0;
	int   sent_count = 0;
	int   taken      = 0;
	int   hold_left  = 0;
	int   cycles     = 0;
	int   result_count;
	int   fail_count;

	initial begin
		forever #5 clk = ~clk;
	end

	moving_average_filter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	mavg_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.result_count(result_count),
		.fail_count  (fail_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off so the block backs up
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			taken <= taken + 1;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (taken == 400 && !held) begin
			held      <= 1'b1;
			hold_left <= 600;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 12);
		end
	end

	task automatic send(logic [SAMPLE_BITS-1:0] smp, logic clr);
		while (!calm && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= clr;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		sent_count++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (result_count < sent_count)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_window(logic [CFG_W-1:0] w);
		drain();
		cfg_wdata <= w;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(19))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'hFFFF;
			3:       return 16'h0000;
			4, 5:    return 16'($urandom_range(511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [CFG_W-1:0] w;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default window of 4: fill with extremes, slide, clear
		repeat (5) send(16'h7FFF, 1'b0);
		repeat (4) send(16'h8000, 1'b0);
		send(16'hFFFF, 1'b0);
		send(16'h0001, 1'b0);
		send(16'h5555, 1'b1);
		send(16'hAAAA, 1'b0);
		// zero acts as 1; window already wider keeps its length
		set_window(7'd0);
		send(16'd100, 1'b0);
		send(-16'sd7, 1'b0);
		send(-16'sd7, 1'b1);
		send(16'd3, 1'b0);
		// above the buffer depth saturates
		set_window(7'd127);
		send(16'd1234, 1'b1);
		send(-16'sd3, 1'b0);
		send(16'd5, 1'b0);

		for (int p = 0; p < 12; p++) begin
			case (p)
				0:       w = 7'd64;
				1:       w = 7'd1;
				3:       w = 7'd127;
				4:       w = 7'd0;
				5:       w = 7'($urandom_range(127));
				default: w = 7'($urandom_range(1, 64));
			endcase
			set_window(w);
			calm <= (p == 0);
			for (int i = 0; i < 140; i++) begin
				if (p == 0) begin
					// full 64-deep window pinned at each rail
					if ($urandom_range(9) == 0)
						send(pick_sample(), i == 0);
					else
						send((i < 70) ? 16'h7FFF : 16'h8000, i == 0);
				end else begin
					send(pick_sample(), $urandom_range(99) < 3);
				end
			end
		end

		drain();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mavg_pkg.sv
rtl/core/mavg_div.sv
rtl/core/mavg_dp.sv
rtl/core/mavg_ctrl.sv
rtl/core/moving_average_filter.sv
tb/mavg_checker.sv
tb/tb.sv
